FILE: rtl/kwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

	// Store geometry.
	localparam int LISTS     = 8;
	localparam int DEPTH     = 64;
	localparam int LIST_W    = (LISTS > 1) ? $clog2(LISTS) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int MEM_DEPTH = LISTS * DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// Field widths fixed by the item formats.
	localparam int FUNC_W   = 2;
	localparam int IDX_W    = 3;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;

	// Depth of the two small queues.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// Function codes on the input side.
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PULL  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// Status codes on the result side.
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_VALUE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [IDX_W-1:0]        list_index;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic signed [VAL_W-1:0] out_value;
		logic [IDX_W-1:0]        from_list;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_PULL,
		OP_CLEAR,
		OP_NOP
	} op_t;

	// A classified command as it waits between front and back.
	typedef struct packed {
		op_t                     op;
		logic                    list_ok;
		logic [LIST_W-1:0]       list;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_LAST
	} bk_state_t;

endpackage

`default_nettype wire

FILE: rtl/kwm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module kwm_front import kwm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t item,
	output logic          cmd_valid,
	output cmd_t          cmd,
	input  wire logic     cmd_pop
);

	cmd_t              dec;
	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	// Classify the item: decode the function and check the list number.
	always_comb begin
		dec.list_ok = (32'(item.list_index) < 32'(LISTS));
		dec.list    = LIST_W'(item.list_index);
		dec.value   = item.value;
		case (item.func)
			FUNC_LOAD:  dec.op = OP_LOAD;
			FUNC_PULL:  dec.op = OP_PULL;
			FUNC_CLEAR: dec.op = OP_CLEAR;
			default:    dec.op = OP_NOP;
		endcase
	end

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign cmd_valid = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/kwm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module kwm_back import kwm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	output logic      res_push,
	output out_item_t res,
	input  wire logic res_full
);

	bk_state_t               state_q;
	bk_state_t               state_d;
	logic [LIST_W-1:0]       scan_q;
	logic [CNT_W-1:0]        fill_q [LISTS];
	logic [CNT_W-1:0]        rc_q [LISTS];
	logic signed [VAL_W-1:0] mem [MEM_DEPTH];
	logic signed [VAL_W-1:0] rd_data_q;
	logic                    rd_vld_s1;
	logic [LIST_W-1:0]       rd_list_s1;
	logic                    found_q;
	logic [LIST_W-1:0]       best_list_q;
	logic signed [VAL_W-1:0] best_val_q;
	logic                    start;
	logic                    load_ok;
	logic                    mem_we;
	logic                    clr;
	logic                    adv;
	logic                    rd_issue;
	logic [ADDR_W-1:0]       wr_addr;
	logic [ADDR_W-1:0]       rd_addr;
	logic                    cand_take;
	logic                    fin_found;
	logic [LIST_W-1:0]       fin_list;
	logic signed [VAL_W-1:0] fin_val;

	assign start   = cmd_valid && !res_full;
	assign load_ok = cmd.list_ok && (fill_q[cmd.list] < CNT_W'(DEPTH));
	assign wr_addr = ADDR_W'(cmd.list) * ADDR_W'(DEPTH) + ADDR_W'(fill_q[cmd.list]);
	assign rd_addr = ADDR_W'(scan_q) * ADDR_W'(DEPTH) + ADDR_W'(rc_q[scan_q]);

	// Running minimum; the strict compare keeps the lowest list on a tie.
	assign cand_take = rd_vld_s1 && (!found_q || (rd_data_q < best_val_q));
	assign fin_found = found_q || cand_take;
	assign fin_list  = cand_take ? rd_list_s1 : best_list_q;
	assign fin_val   = cand_take ? rd_data_q : best_val_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (start && (cmd.op == OP_PULL)) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (scan_q == LIST_W'(LISTS - 1)) begin
					state_d = BK_LAST;
				end
			end
			BK_LAST: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop       = 1'b0;
		res_push      = 1'b0;
		res.status    = ST_DONE;
		res.out_value = '0;
		res.from_list = '0;
		mem_we        = 1'b0;
		clr           = 1'b0;
		adv           = 1'b0;
		rd_issue      = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (start) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_LOAD: begin
							res_push   = 1'b1;
							mem_we     = load_ok;
							res.status = load_ok ? ST_DONE : ST_FULL;
						end
						OP_PULL: begin
							res_push = 1'b0;
						end
						OP_CLEAR: begin
							res_push = 1'b1;
							clr      = 1'b1;
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			BK_SCAN: begin
				rd_issue = (rc_q[scan_q] != fill_q[scan_q]);
			end
			BK_LAST: begin
				res_push = 1'b1;
				adv      = fin_found;
				if (fin_found) begin
					res.status    = ST_VALUE;
					res.out_value = fin_val;
					res.from_list = IDX_W'(fin_list);
				end else begin
					res.status = ST_EMPTY;
				end
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= cmd.value;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		rd_list_s1 <= scan_q;
		if (cand_take) begin
			best_list_q <= rd_list_s1;
			best_val_q  <= rd_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			for (int l = 0; l < LISTS; l++) begin
				fill_q[l] <= '0;
				rc_q[l]   <= '0;
			end
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			if (state_q == BK_SCAN) begin
				scan_q <= scan_q + LIST_W'(1);
			end else begin
				scan_q <= '0;
			end
			if (state_q == BK_IDLE) begin
				found_q <= 1'b0;
			end else if (cand_take) begin
				found_q <= 1'b1;
			end
			for (int l = 0; l < LISTS; l++) begin
				if (clr) begin
					fill_q[l] <= '0;
					rc_q[l]   <= '0;
				end else begin
					if (mem_we && (cmd.list == LIST_W'(l))) begin
						fill_q[l] <= fill_q[l] + CNT_W'(1);
					end
					if (adv && (fin_list == LIST_W'(l))) begin
						rc_q[l] <= rc_q[l] + CNT_W'(1);
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_res_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full result queue");

	a_no_fetch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE) |-> !cmd_pop)
		else $error("command taken while a pull is being scanned");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (fill_q[cmd.list] < CNT_W'(DEPTH)))
		else $error("store write beyond the end of a list");

	a_pull_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_LAST) |=> (state_q == BK_IDLE))
		else $error("pull did not finish after its last compare");
`endif

endmodule

`default_nettype wire

FILE: rtl/kwm_res_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module kwm_res_queue import kwm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      res_push,
	input  wire out_item_t res,
	output logic           res_full,
	output logic           empty,
	output out_item_t      result,
	input  wire logic      pop
);

	out_item_t         slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign res_full = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;
	assign result   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/k_way_sorted_merge.sv
// A load, clear or unused function passes through the front queue and the back end into the
// result queue; a pull is answered once its scan of every list head is done.
// Throughput: one load or clear per cycle while the result queue has room; a pull holds the
// back end for its scan, one list head per cycle through the single store read port.
// Reset: arst_n clears the queues, the sequencer and all fill and read counts at once;
// the list store itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module k_way_sorted_merge import kwm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t item,
	output logic          empty,
	output out_item_t     result,
	input  wire logic     pop
);

	// The front end decodes each transferred item into a command and holds up to two of
	// them, so the source can keep pushing while the back end is busy with a pull.
	logic      cmd_valid;
	cmd_t      cmd;
	logic      cmd_pop;

	// The back end only starts a command when the result queue has room, so every result
	// it writes is guaranteed a slot and nothing is ever lost or held in the back end.
	logic      res_push;
	out_item_t res;
	logic      res_full;

	kwm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// The back end owns the list store and the per-list counters. A load writes the tail
	// of its list in the cycle it is taken; a pull scans the head of every list, one per cycle, keeping
	// the smallest so far, then advances the winning list.
	kwm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	// Results wait here until the sink takes them, in the order they were produced.
	kwm_res_queue u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.result   (result),
		.pop      (pop)
	);

endmodule

`default_nettype wire

FILE: sim/merge_checker.sv
`timescale 1ns / 1ps

module merge_checker import kwm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic      full,
	input  in_item_t  item,
	input  logic      empty,
	input  out_item_t result,
	input  logic      pop,
	output int        failures,
	output int        pending
);

	// Shadow copy of the list stores and their counters.
	logic signed [VAL_W-1:0] list_data [LISTS][DEPTH];
	int                      fill_cnt [LISTS];
	int                      read_cnt [LISTS];
	out_item_t               due_results [$];

	// Works out the answer to one command and updates the shadow lists.
	function automatic out_item_t merge_next(input in_item_t it);
		out_item_t               r;
		int                      best;
		logic signed [VAL_W-1:0] best_val;
		logic signed [VAL_W-1:0] head;
		r = '0;
		best = -1;
		best_val = '0;
		case (it.func)
		FUNC_LOAD: begin
			if (int'(it.list_index) >= LISTS || fill_cnt[it.list_index] >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				list_data[it.list_index][fill_cnt[it.list_index]] = it.value;
				fill_cnt[it.list_index]++;
				r.status = ST_DONE;
			end
		end
		FUNC_PULL: begin
			// Strict less-than keeps the lowest list on a tie.
			for (int l = 0; l < LISTS; l++) begin
				if (read_cnt[l] < fill_cnt[l]) begin
					head = list_data[l][read_cnt[l]];
					if (best < 0 || head < best_val) begin
						best = l;
						best_val = head;
					end
				end
			end
			if (best < 0) begin
				r.status = ST_EMPTY;
			end else begin
				read_cnt[best]++;
				r.status = ST_VALUE;
				r.out_value = best_val;
				r.from_list = IDX_W'(best);
			end
		end
		FUNC_CLEAR: begin
			for (int l = 0; l < LISTS; l++) begin
				fill_cnt[l] = 0;
				read_cnt[l] = 0;
			end
			r.status = ST_DONE;
		end
		default: begin
			r.status = ST_DONE;
		end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		failures++;
		$display("%0t: mismatch in %s: got 0x%h, expected 0x%h", $realtime, what, got, want);
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (due_results.size() == 0) begin
			report_mismatch("result with nothing outstanding", got.out_value, '0);
			return;
		end
		want = due_results.pop_front();
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.out_value !== want.out_value)
			report_mismatch("out_value", got.out_value, want.out_value);
		if (got.from_list !== want.from_list)
			report_mismatch("from_list", 32'(got.from_list), 32'(want.from_list));
	endtask

	// A result can never leave in the cycle its command arrives, so the
	// check runs before the new expectation is queued.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_results.delete();
			for (int l = 0; l < LISTS; l++) begin
				fill_cnt[l] = 0;
				read_cnt[l] = 0;
			end
			failures = 0;
			pending <= 0;
		end else begin
			if (pop && !empty)
				check_result(result);
			if (push && !full)
				due_results = {due_results, merge_next(item)};
			pending <= due_results.size();
		end
	end

endmodule

FILE: sim/tb_k_way_sorted_merge.sv
`timescale 1ns / 1ps

module tb_k_way_sorted_merge;
	import kwm_pkg::*;

	// The unused function code; the block must still answer it.
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
	localparam int RANDOM_ITEMS  = 650;
	// This margin lets any straggling pull finish.
	localparam int SETTLE_CYCLES = LISTS + 8;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	out_item_t result;
	logic      pop;
	int        failures;
	int        pending;
	int        sent;
	bit        tx_quiet;
	bit        rx_quiet;

	// Per-list plan for the merge phases: how many values remain to be loaded
	// and the next value, which only ever grows so that each list is sorted.
	int                      to_load  [LISTS];
	logic signed [VAL_W-1:0] tail_val [LISTS];

	always #6 clk = ~clk;

	k_way_sorted_merge u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.result (result),
		.pop    (pop)
	);

	merge_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.result   (result),
		.pop      (pop),
		.failures (failures),
		.pending  (pending)
	);

	// The run is ended here if the block stops answering.
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Each side waits a random number of cycles before every transfer, except
	// during quiet stretches, in which it runs flat out.
	function automatic int wait_draw(input bit quiet);
		if (quiet)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic in_item_t cmd_item(input logic [FUNC_W-1:0] f,
			input logic [31:0] idx, input logic [VAL_W-1:0] v);
		in_item_t it;
		it.func = f;
		it.list_index = IDX_W'(idx);
		it.value = v;
		return it;
	endfunction

	// Adds a random step of at most span and saturates at the largest value,
	// which also produces runs of equal values at the top of the range.
	function automatic logic signed [VAL_W-1:0] step_up(input logic signed [VAL_W-1:0] v,
			input int unsigned span);
		longint nxt;
		nxt = longint'(v) + longint'($urandom_range(0, span));
		if (nxt > 64'sh7FFF_FFFF)
			nxt = 64'sh7FFF_FFFF;
		return nxt[VAL_W-1:0];
	endfunction

	// Offers one command and returns at the edge that takes it. Push is only
	// lowered when a gap follows, so back-to-back transfers keep it high.
	task automatic send(input in_item_t it);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_quiet = !tx_quiet;
		gap = wait_draw(tx_quiet);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
	endtask

	// The list and value fields of a pull or a clear are ignored by the block,
	// so they carry random bits.
	task automatic send_pull();
		send(cmd_item(FUNC_PULL, $urandom, $urandom));
	endtask

	task automatic send_clear();
		send(cmd_item(FUNC_CLEAR, $urandom, $urandom));
	endtask

	// The count of outstanding results is registered, so at least one edge
	// passes before it is trusted.
	task automatic wait_drained();
		do @(posedge clk); while (pending != 0);
	endtask

	// A well-formed merge: clear, load a few sorted lists in an interleaved
	// order, then pull everything back, usually with a pull or two too many.
	task automatic merge_phase();
		int                      total;
		int                      loaded;
		int                      pulls;
		int                      l;
		int unsigned             span;
		logic signed [VAL_W-1:0] base;
		total = 0;
		send_clear();
		case ($urandom_range(0, 3))
		0: begin
			base = $urandom;
			span = $urandom_range(1, 1 << 24);
		end
		1: begin
			// Crowded at the most negative value, with many ties.
			base = 32'sh8000_0000;
			span = 3;
		end
		2: begin
			// Small values either side of zero.
			base = $signed($urandom_range(0, 8)) - 4;
			span = 2;
		end
		default: begin
			// Pinned at the most positive value.
			base = 32'sh7FFF_FFF0;
			span = 4;
		end
		endcase
		for (int i = 0; i < LISTS; i++) begin
			to_load[i] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			tail_val[i] = step_up(base, span);
			total += to_load[i];
		end
		loaded = total;
		while (total > 0) begin
			l = $urandom_range(0, LISTS - 1);
			if (to_load[l] != 0) begin
				send(cmd_item(FUNC_LOAD, l, tail_val[l]));
				tail_val[l] = step_up(tail_val[l], span);
				to_load[l]--;
				total--;
				if ($urandom_range(0, 15) == 0)
					send_pull();
			end
		end
		// Now and then the phase stops half way and the next clear discards
		// whatever is left.
		pulls = ($urandom_range(0, 4) == 0) ? loaded / 2 : loaded + $urandom_range(1, 2);
		repeat (pulls) send_pull();
	endtask

	// Fills one list past its depth. Pulls do not give back space, so the
	// load after them is still dropped.
	task automatic overflow_phase();
		int                      l;
		logic signed [VAL_W-1:0] v;
		l = $urandom_range(0, LISTS - 1);
		v = $urandom;
		send_clear();
		repeat (DEPTH + $urandom_range(1, 3)) begin
			send(cmd_item(FUNC_LOAD, l, v));
			v = step_up(v, 1 << 20);
		end
		repeat ($urandom_range(1, 4)) send_pull();
		send(cmd_item(FUNC_LOAD, l, v));
		send_clear();
	endtask

	// Unstructured commands, including the spare function code and loads
	// that break the sorted order.
	task automatic noise_phase();
		repeat ($urandom_range(8, 20)) send(cmd_item(FUNC_W'($urandom), $urandom, $urandom));
	endtask

	initial begin : stimulus
		int target;
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		sent = 0;
		tx_quiet = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A pull straight after reset finds every list empty.
		send_pull();
		// Both ends of the signed range, a negative value ahead of zero in
		// one list, and a tie between lists two and six that list two wins.
		send(cmd_item(FUNC_LOAD, 0, 32'sh8000_0000));
		send(cmd_item(FUNC_LOAD, 7, 32'sh7FFF_FFFF));
		send(cmd_item(FUNC_LOAD, 3, -1));
		send(cmd_item(FUNC_LOAD, 3, 0));
		send(cmd_item(FUNC_LOAD, 6, 5));
		send(cmd_item(FUNC_LOAD, 2, 5));
		// The spare code must change nothing, whatever its other fields hold.
		send(cmd_item(FUNC_SPARE, 7, -1));
		send(cmd_item(FUNC_SPARE, 0, 0));
		// Six values come back in order and the seventh pull finds all empty.
		repeat (7) send_pull();
		// A clear must discard values that were never pulled.
		send(cmd_item(FUNC_LOAD, 4, 32'sh5555_5555));
		send(cmd_item(FUNC_LOAD, 1, 32'shAAAA_AAAA));
		send(cmd_item(FUNC_CLEAR, 7, -1));
		send_pull();

		// Hold off until the block has answered everything so far.
		push <= 1'b0;
		wait_drained();

		// Random part: mostly sorted merges, one guaranteed overflow, and
		// some noise.
		target = sent + RANDOM_ITEMS;
		overflow_phase();
		while (sent < target) begin
			case ($urandom_range(0, 11))
			0: begin
				overflow_phase();
			end
			1, 2: begin
				noise_phase();
			end
			default: begin
				merge_phase();
			end
			endcase
		end
		push <= 1'b0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// The result side takes whatever is offered, after a random stall per
	// transfer, and never stops until the run ends.
	initial begin : drain
		int gap;
		pop <= 1'b0;
		rx_quiet = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_quiet = !rx_quiet;
			gap = wait_draw(rx_quiet);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

endmodule
